### hdl/firad_pkg.sv
// Shared types and constants for the ADC-to-DAC FIR filter.
package firad_pkg;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_SCALE,
        S_RECIP,
        S_FIX
    } t_state;

    // tuser selector codes
    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // Input beat layout
    localparam int IN_DATA_W = 40;
    localparam int ADC_W     = 12;
    localparam int DAC_W     = 8;

    localparam logic [ADC_W-1:0] ADC_MAX = 12'hFFF;

    // y*255/4095 reduces to y*17/273
    localparam int X_W = 17;
    localparam logic [X_W-1:0] SCALE_NUM = 17'd17;
    localparam logic [X_W-1:0] DIV_DEN   = 17'd273;

    // floor(2^24/273); quotient from it is low by at most one
    localparam int RECIP_SH = 24;
    localparam logic [15:0] RECIP_M = 16'd61455;

endpackage

### hdl/fir_filter_adc_to_dac.sv
// Timing: a coefficient load beat completes in the cycle it is accepted.
// A sample beat passes through the RUN, DRAIN, SCALE, RECIP and FIX states before its
// result is registered, when tready also returns, so a new sample is not accepted until
// the last result is loaded, the single multiply-accumulate unit stepping one tap per cycle over both RAMs.
// Reset: synchronous active-low; both stores read as zero after reset through
// per-entry valid bits, with no clearing pass.
module fir_filter_adc_to_dac #(
    parameter int TAPS       = 64,
    parameter int COEF_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [5:0] coef_index, [21:6] coef_value, [33:22] adc_sample, [39:34] zero
    input  logic [firad_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] action
    input  logic [0:0]                     s_axis_tuser,
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] dac_code
    output logic [firad_pkg::DAC_W-1:0]    m_axis_tdata
);

    import firad_pkg::*;

    localparam int TAP_W  = $clog2(TAPS);
    localparam int PROD_W = COEF_WIDTH + ADC_W + 1;
    localparam int ACC_W  = PROD_W + TAP_W;
    localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(TAPS - 1);

    // Input field extraction
    logic [5:0]       w_coef_index;
    logic [15:0]      w_coef_value;
    logic [ADC_W-1:0] w_adc_sample;
    logic             w_is_sample;
    logic [8:0]       w_idx9;
    logic             w_idx_ok;
    logic [31:0]      w_coef32;

    assign w_coef_index = s_axis_tdata[5:0];
    assign w_coef_value = s_axis_tdata[21:6];
    assign w_adc_sample = s_axis_tdata[33:22];
    assign w_is_sample  = (s_axis_tuser[0] == ACT_SAMPLE);
    assign w_idx9       = 9'(w_coef_index);
    assign w_idx_ok     = (w_idx9 < 9'(TAPS));
    assign w_coef32     = 32'($signed(w_coef_value));

    // Control
    t_state           r_state, n_state;
    logic             w_accept;
    logic             w_start;
    logic             w_load;
    logic             w_issue;
    logic             w_out_load;

    logic [TAP_W-1:0] r_tap;
    logic [TAP_W-1:0] r_rd_pos;
    logic [TAP_W-1:0] r_wr_pos;
    logic [TAPS-1:0]  r_coef_valid;
    logic [TAPS-1:0]  r_hist_valid;
    logic             r_iss;
    logic             r_prod_vld;
    logic             r_cv_q;
    logic             r_hv_q;
    logic             r_out_valid;

    // Datapath
    logic [COEF_WIDTH-1:0]    w_coef_rd;
    logic [ADC_W-1:0]         w_hist_rd;
    logic signed [COEF_WIDTH-1:0] w_coef_eff;
    logic signed [ADC_W:0]    w_hist_eff;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [ADC_W-1:0]         w_y;
    logic [X_W-1:0]           r_x;
    logic [32:0]              w_recip;
    logic [DAC_W-1:0]         r_q0;
    logic [X_W-1:0]           w_rem;
    logic [DAC_W-1:0]         w_q;
    logic [DAC_W-1:0]         r_out_data;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_start  = w_accept && w_is_sample;
    assign w_load   = w_accept && !w_is_sample && w_idx_ok;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_tap == LAST_TAP) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!r_iss && !r_prod_vld) n_state = S_SCALE;
            end
            S_SCALE: n_state = S_RECIP;
            S_RECIP: n_state = S_FIX;
            S_FIX: begin
                if (w_out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_issue       = 1'b0;
        w_out_load    = 1'b0;
        case (r_state)
            S_IDLE:  s_axis_tready = 1'b1;
            S_RUN:   w_issue = 1'b1;
            S_FIX:   w_out_load = !r_out_valid || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_tap        <= '0;
            r_rd_pos     <= '0;
            r_wr_pos     <= '0;
            r_coef_valid <= '0;
            r_hist_valid <= '0;
            r_iss        <= 1'b0;
            r_prod_vld   <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_iss      <= w_issue;
            r_prod_vld <= r_iss;
            if (w_load) begin
                r_coef_valid[w_idx9[TAP_W-1:0]] <= 1'b1;
            end
            if (w_start) begin
                r_hist_valid[r_wr_pos] <= 1'b1;
                r_tap    <= '0;
                r_rd_pos <= r_wr_pos;
                r_wr_pos <= (r_wr_pos == LAST_TAP) ? '0 : r_wr_pos + 1'b1;
            end
            // advance tap and walk history from newest to oldest
            if (w_issue) begin
                r_tap    <= r_tap + 1'b1;
                r_rd_pos <= (r_rd_pos == '0) ? LAST_TAP : r_rd_pos - 1'b1;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    firad_ram #(
        .WIDTH(COEF_WIDTH),
        .DEPTH(TAPS)
    ) u_coef_ram (
        .i_clk  (i_clk),
        .i_we   (w_load),
        .i_waddr(w_idx9[TAP_W-1:0]),
        .i_wdata(w_coef32[COEF_WIDTH-1:0]),
        .i_raddr(r_tap),
        .o_rdata(w_coef_rd)
    );

    firad_ram #(
        .WIDTH(ADC_W),
        .DEPTH(TAPS)
    ) u_hist_ram (
        .i_clk  (i_clk),
        .i_we   (w_start),
        .i_waddr(r_wr_pos),
        .i_wdata(w_adc_sample),
        .i_raddr(r_rd_pos),
        .o_rdata(w_hist_rd)
    );

    // Entries never written read as zero
    assign w_coef_eff = r_cv_q ? $signed(w_coef_rd) : '0;
    assign w_hist_eff = r_hv_q ? $signed({1'b0, w_hist_rd}) : '0;

    // Clamp the Q-shifted sum to the ADC range
    always_comb begin
        if (r_acc[ACC_W-1]) begin
            w_y = '0;
        end else if (|r_acc[ACC_W-2:COEF_WIDTH+ADC_W-1]) begin
            w_y = ADC_MAX;
        end else begin
            w_y = r_acc[COEF_WIDTH+ADC_W-2:COEF_WIDTH-1];
        end
    end

    assign w_recip = 33'(r_x) * 33'(RECIP_M);
    assign w_rem   = r_x - X_W'(r_q0) * DIV_DEN;
    assign w_q     = r_q0 + DAC_W'(w_rem >= DIV_DEN);

    always_ff @(posedge i_clk) begin
        r_cv_q <= r_coef_valid[r_tap];
        r_hv_q <= r_hist_valid[r_rd_pos];
        r_prod <= w_coef_eff * w_hist_eff;
        if (w_start) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_acc + {{TAP_W{r_prod[PROD_W-1]}}, r_prod};
        end
        if (r_state == S_SCALE) begin
            r_x <= X_W'(w_y) * SCALE_NUM;
        end
        if (r_state == S_RECIP) begin
            r_q0 <= w_recip[RECIP_SH+DAC_W-1:RECIP_SH];
        end
        if (w_out_load) begin
            r_out_data <= w_q;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Reciprocal quotient is never more than one short
    a_recip_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIX) |-> (w_rem < 2 * DIV_DEN))
        else $error("reciprocal quotient off by more than one");

    // Scaling must see a fully drained accumulator
    a_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCALE) |-> (!r_iss && !r_prod_vld))
        else $error("scale started with taps in flight");

    // Circular pointers stay inside the store
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_pos < TAPS) && (r_rd_pos < TAPS) && (r_tap < TAPS))
        else $error("pointer beyond TAPS");

    // A sample beat starts a fresh tap sweep at the newest entry
    a_start_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == S_RUN) && (r_tap == '0) && (r_rd_pos == $past(r_wr_pos)))
        else $error("sweep did not start at newest sample");

    // A pending result is not overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> $stable(r_out_data))
        else $error("pending result overwritten");

endmodule

### hdl/firad_ram.sv
// Generic single-write, single-read RAM with registered read data.
module firad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### sim/tb_fir_filter_adc_to_dac.sv
// Self-checking stream testbench for the ADC-to-DAC FIR filter.
module tb_fir_filter_adc_to_dac;
    import firad_pkg::*;

    localparam int TAPS        = 64;
    localparam int TAP_W       = $clog2(TAPS);
    localparam int COEF_WIDTH  = 16;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = TAPS + 20;
    localparam int MAX_LINES   = 40;

    typedef struct {
        logic               action;
        logic [5:0]         coef_index;
        logic signed [15:0] coef_value;
        logic [ADC_W-1:0]   adc_sample;
        bit                 hold_for_drain;
        int                 idle_pct;
    } t_fir_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // [5:0] coef_index, [21:6] coef_value, [33:22] adc_sample, [39:34] zero
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    // [0] action
    logic [0:0]           s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] dac_code
    logic [DAC_W-1:0]     m_axis_tdata;

    t_fir_beat        filter_cmds[$];
    logic [DAC_W-1:0] dac_expected[$];
    t_fir_beat        on_bus;
    logic [DAC_W-1:0] dac_want;

    // Mirror of the filter state
    logic [ADC_W-1:0]   hist_mirror [TAPS];
    logic signed [15:0] coef_mirror [TAPS];
    logic [TAP_W-1:0]   wr_pos;

    bit in_taken;
    bit hold_next;
    bit hung;
    int fill_idle_pct;
    int rx_idle_pct = 20;
    int gap_left;
    int stall_left;
    int quiet_cycles;
    int n_errors;
    int n_total;
    int n_accepted;
    int n_loads;
    int n_samples;
    int n_checked;
    int n_zero;
    int n_full;

    fir_filter_adc_to_dac #(
        .TAPS       (TAPS),
        .COEF_WIDTH (COEF_WIDTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        if (n_errors <= MAX_LINES) begin
            $display("[%0t] MISMATCH %s", $time, what);
        end
    endtask

    // Apply one accepted beat to the mirror and queue the dac code it yields
    task automatic fir_update(input t_fir_beat b);
        longint           acc;
        longint           y;
        logic [TAP_W-1:0] p;
        int               i;
        logic [DAC_W-1:0] code;
        acc = 0;
        if (b.action == ACT_LOAD) begin
            coef_mirror[b.coef_index] = b.coef_value;
            n_loads++;
        end else begin
            n_samples++;
            hist_mirror[wr_pos] = b.adc_sample;
            p = wr_pos;
            for (i = 0; i < TAPS; i++) begin
                acc += longint'(coef_mirror[TAP_W'(i)]) * longint'(hist_mirror[p]);
                p = (p == '0) ? TAP_W'(TAPS - 1) : p - 1'b1;
            end
            if (acc < 0) begin
                y = 0;
            end else begin
                y = acc >>> (COEF_WIDTH - 1);
                if (y > 4095) y = 4095;
            end
            code = DAC_W'(y * 255 / 4095);
            if (code == 0) n_zero++;
            if (code == 255) n_full++;
            dac_expected.push_back(code);
            wr_pos = (wr_pos == TAP_W'(TAPS - 1)) ? '0 : wr_pos + 1'b1;
        end
    endtask

    function automatic void add_item(logic act, int idx, int val, int sample);
        t_fir_beat b;
        b.action         = act;
        b.coef_index     = 6'(idx);
        b.coef_value     = 16'(val);
        b.adc_sample     = ADC_W'(sample);
        b.hold_for_drain = hold_next;
        b.idle_pct       = fill_idle_pct;
        hold_next = 1'b0;
        filter_cmds.push_back(b);
    endfunction

    // Unused fields carry random bits on both kinds of beat
    function automatic void load_coef(int idx, int val);
        add_item(ACT_LOAD, idx, val, $urandom_range(4095));
    endfunction

    function automatic void feed_adc(int sample);
        add_item(ACT_SAMPLE, $urandom_range(63), $urandom_range(65535), sample);
    endfunction

    function automatic int pick_coef(int mode);
        case (mode)
            0:       return $urandom_range(1024);
            1:       return int'($urandom_range(4096)) - 2048;
            2:       return $urandom_range(65535);
            default: return ($urandom_range(7) == 0) ? int'($urandom_range(65535)) : 0;
        endcase
    endfunction

    function automatic int pick_adc();
        case ($urandom_range(7))
            0:       return 0;
            1:       return int'(ADC_MAX);
            default: return $urandom_range(4095);
        endcase
    endfunction

    // Sender: present the next queued beat at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_axis_tvalid <= 1'b0;
            end else if (filter_cmds.size() == 0 ||
                         (filter_cmds[0].hold_for_drain && dac_expected.size() != 0)) begin
                s_axis_tvalid <= 1'b0;
            end else if ($urandom_range(99) < filter_cmds[0].idle_pct) begin
                gap_left = $urandom_range(9);
                s_axis_tvalid <= 1'b0;
            end else begin
                on_bus = filter_cmds.pop_front();
                rx_idle_pct = on_bus.idle_pct;
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {{(IN_DATA_W - 34){1'b0}}, on_bus.adc_sample,
                                 on_bus.coef_value, on_bus.coef_index};
                s_axis_tuser <= on_bus.action;
            end
        end
    end

    // Receiver: stall in bursts
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(99) < rx_idle_pct / 2) begin
            stall_left = $urandom_range(9);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Monitor: predict on input beats, check output beats, watch for a hang
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_taken = 1'b1;
                n_accepted++;
                fir_update(on_bus);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (dac_expected.size() == 0) begin
                    report_mismatch($sformatf("unexpected dac_code %0d", m_axis_tdata));
                end else begin
                    dac_want = dac_expected.pop_front();
                    if (m_axis_tdata !== dac_want) begin
                        report_mismatch($sformatf("dac_code got %0d want %0d at result %0d",
                                                  m_axis_tdata, dac_want, n_checked));
                    end
                    n_checked++;
                end
            end
            if (in_taken || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= QUIET_LIMIT) begin
                hung = 1'b1;
            end
        end
    end

    initial begin
        int k;
        int blk;
        int mode;
        int n_coefs;
        int n_adc;
        hist_mirror = '{default: '0};
        coef_mirror = '{default: '0};
        wr_pos = '0;
        fill_idle_pct = 20;

        // Directed: empty store, unity tap, clamp high, negative sum, index extremes
        feed_adc(int'(ADC_MAX));
        load_coef(0, 32767);
        feed_adc(int'(ADC_MAX));
        feed_adc(0);
        load_coef(1, 32767);
        feed_adc(int'(ADC_MAX));
        feed_adc(int'(ADC_MAX));
        load_coef(0, -32768);
        load_coef(1, 0);
        feed_adc(int'(ADC_MAX));
        load_coef(63, -1);
        load_coef(0, 16384);
        feed_adc(2048);
        feed_adc(1);
        load_coef(0, 1);
        feed_adc(int'(ADC_MAX));
        load_coef(2, -32768);
        load_coef(0, 32767);
        feed_adc(4000);
        load_coef(63, 32767);
        feed_adc(int'(ADC_MAX));

        // Random: coefficient sets followed by sample runs, with stray loads
        hold_next = 1'b1;
        blk = 0;
        while (filter_cmds.size() < 620) begin
            if (filter_cmds.size() > 540) begin
                fill_idle_pct = 0;
            end else begin
                case ($urandom_range(3))
                    0:       fill_idle_pct = 0;
                    1:       fill_idle_pct = 10;
                    2:       fill_idle_pct = 25;
                    default: fill_idle_pct = 50;
                endcase
            end
            if (blk == 6) hold_next = 1'b1;
            mode = $urandom_range(3);
            n_coefs = ($urandom_range(3) == 0) ? TAPS : $urandom_range(12, 1);
            for (k = 0; k < n_coefs; k++) begin
                load_coef((n_coefs == TAPS) ? k : $urandom_range(TAPS - 1), pick_coef(mode));
            end
            n_adc = $urandom_range(24, 4);
            for (k = 0; k < n_adc; k++) begin
                if ($urandom_range(11) == 0) begin
                    load_coef($urandom_range(TAPS - 1), pick_coef(mode));
                end else begin
                    feed_adc(pick_adc());
                end
            end
            blk++;
        end
        n_total = filter_cmds.size();

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!hung && (n_accepted != n_total || dac_expected.size() != 0)) begin
            @(negedge i_clk);
        end
        if (!hung) begin
            repeat (TAIL_CYCLES) @(negedge i_clk);
        end

        if (hung) begin
            $display("watchdog: no beat moved for %0d cycles", QUIET_LIMIT);
        end
        if (dac_expected.size() != 0) begin
            report_mismatch($sformatf("%0d dac codes never arrived", dac_expected.size()));
        end
        $display("covered %0d coefficient loads and %0d ADC samples, %0d dac codes checked",
                 n_loads, n_samples, n_checked);
        $display("expected codes: %0d at zero, %0d at full scale, %0d in between",
                 n_zero, n_full, n_samples - n_zero - n_full);
        if (!hung && n_errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
